// ----- rtl/fcc_pkg.sv -----
// Shared types and constants for the framed CRC-16-CCITT checker.
// No dependencies; every other file imports this package.
`default_nettype none
package fcc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned CNT_W  = 3;

  localparam logic [CRC_W-1:0] CRC_POLY     = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_SEED_RST = 16'h0000;

  // bytes seen before the current one: CRC runs from the fourth byte on,
  // the count stops at four
  localparam logic [CNT_W-1:0] CNT_CRC_START = 3'd3;
  localparam logic [CNT_W-1:0] CNT_SAT       = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [CRC_W-1:0]  computed_crc;
    logic [CRC_W-1:0]  received_crc;
  } res_t;

  // handshake between the input stage and the core
  typedef struct packed {
    logic  valid;
    logic  advance;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/fcc_ifs.sv -----
// Channel interfaces: byte input, result output, seed configuration.
// Depends on fcc_pkg for field widths.
`default_nettype none
interface fcc_in_if import fcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcc_out_if import fcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [CRC_W-1:0] computed_crc;
  logic [CRC_W-1:0] received_crc;

  modport source (output valid, output status, output computed_crc,
                  output received_crc, input ready);
  modport sink   (input valid, input status, input computed_crc,
                  input received_crc, output ready);
endinterface

interface fcc_cfg_if import fcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CRC_W-1:0] crc_seed;

  modport source (output valid, output crc_seed, input ready);
  modport sink   (input valid, input crc_seed, output ready);
endinterface
`default_nettype wire

// ----- rtl/fcc_in_stage.sv -----
// Input register: captures one byte beat, holds it until the core takes it.
// Depends on fcc_pkg.
`default_nettype none
module fcc_in_stage import fcc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule
`default_nettype wire

// ----- rtl/fcc_core.sv -----
// Frame state, CRC byte step and end-of-frame compare.
// Depends on fcc_pkg.
`default_nettype none
module fcc_core import fcc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire stage_ctl_t       ctl,
  input  wire item_t            item,
  input  wire logic             seed_we,
  input  wire logic [CRC_W-1:0] seed_wdata,
  output logic                  res_valid,
  output res_t                  res
);

  logic [CRC_W-1:0]  seed_r;
  logic [CRC_W-1:0]  crc_r,  crc_nxt;
  logic [BYTE_W-1:0] win0_r, win0_nxt;
  logic [BYTE_W-1:0] win1_r, win1_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [CRC_W-1:0]  crc_cur;
  logic [CRC_W-1:0]  rx_crc;

  // MSB-first byte update, eight shift/xor steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // start byte reloads the seed
  assign crc_cur = (cnt_r == '0) ? seed_r : crc_r;
  assign rx_crc  = {win0_r, win1_r};

  always_comb begin
    res_valid        = ctl.advance && item.last_byte;
    res.status       = ST_SHORT;
    res.computed_crc = '0;
    res.received_crc = '0;
    if (cnt_r >= CNT_CRC_START) begin
      res.status       = (crc_cur == rx_crc) ? ST_OK : ST_MISMATCH;
      res.computed_crc = crc_cur;
      res.received_crc = rx_crc;
    end
  end

  always_comb begin
    crc_nxt  = crc_r;
    win0_nxt = win0_r;
    win1_nxt = win1_r;
    cnt_nxt  = cnt_r;
    if (ctl.advance) begin
      if (item.last_byte) begin
        crc_nxt  = seed_r;
        win0_nxt = '0;
        win1_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        crc_nxt  = (cnt_r >= CNT_CRC_START) ? crc_byte(crc_cur, win0_r) : crc_cur;
        win0_nxt = win1_r;
        win1_nxt = item.data_byte;
        cnt_nxt  = (cnt_r < CNT_SAT) ? cnt_r + 1'b1 : cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= CRC_SEED_RST;
      crc_r  <= CRC_SEED_RST;
      win0_r <= '0;
      win1_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (seed_we) begin
        seed_r <= seed_wdata;
      end
      crc_r  <= crc_nxt;
      win0_r <= win0_nxt;
      win1_r <= win1_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fcc_out_stage.sv -----
// Result register: holds one result beat until the sink takes it.
// Depends on fcc_pkg.
`default_nettype none
module fcc_out_stage import fcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t load_res,
  output logic      free,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// ----- rtl/framed_crc16_ccitt_checker.sv -----
// Framed CRC-16-CCITT checker, top level.
// An end byte passes the input register, then the result register, before out_ch.valid rises.
// Throughput: one byte per cycle while no end byte waits; input register -> one CRC byte step -> result reg.
// An end byte waits in the input register only while the result register is full and out_ch.ready is low.
// Reset (rst_n low, synchronous): clears frame state, seed to 0, both stages empty.
// Depends on fcc_pkg, fcc_ifs, fcc_in_stage, fcc_core, fcc_out_stage.
`default_nettype none
module framed_crc16_ccitt_checker import fcc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  fcc_in_if.sink    in_ch,
  fcc_out_if.source out_ch,
  fcc_cfg_if.sink   cfg_ch
);

  item_t      in_item;
  item_t      s1_item;
  stage_ctl_t s1_ctl;
  logic       advance;
  logic       out_free;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.last_byte = in_ch.last_byte;

  // seed register is always writable; the user must write it only between frames, the block does not enforce this
  assign cfg_ch.ready = 1'b1;

  // a buffered byte moves on unless it ends a frame and the result slot is busy
  assign advance = s1_ctl.valid && (!s1_item.last_byte || out_free);

  fcc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .ctl      (s1_ctl),
    .item     (s1_item)
  );

  // CRC runs two bytes behind the stream so the CRC and end bytes stay out
  fcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (s1_ctl),
    .item       (s1_item),
    .seed_we    (cfg_ch.valid),
    .seed_wdata (cfg_ch.crc_seed),
    .res_valid  (res_valid),
    .res        (res)
  );

  fcc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_res  (res),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.status       = out_res.status;
  assign out_ch.computed_crc = out_res.computed_crc;
  assign out_ch.received_crc = out_res.received_crc;

endmodule
`default_nettype wire

// ----- rtl/fcc_checker.sv -----
// Port-level assertions for the checker, bound to the top level.
// Depends on fcc_pkg and framed_crc16_ccitt_checker.
`default_nettype none
module fcc_checker import fcc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [1:0]       status,
  input wire logic [CRC_W-1:0] computed_crc,
  input wire logic [CRC_W-1:0] received_crc
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_SHORT |-> computed_crc == '0 && received_crc == '0)
    else $error("short frame with nonzero CRC fields");

  a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_SHORT |->
      ((status == ST_OK) == (computed_crc == received_crc)) &&
      (status == ST_OK || status == ST_MISMATCH))
    else $error("status disagrees with CRC compare");

endmodule

bind framed_crc16_ccitt_checker fcc_checker u_fcc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .computed_crc (out_ch.computed_crc),
  .received_crc (out_ch.received_crc)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for framed_crc16_ccitt_checker: byte-stream frames in, one verdict beat per frame out.
// Depends on fcc_pkg, fcc_ifs and the RTL top; self-checking, no external files.
`timescale 1ns / 100ps
module tb_top;
  import fcc_pkg::*;

  // Settle time after the last expected verdict.
  localparam int DRAIN_CYCLES = 6;
  // Generous wall: ~1600 beats with their worst-case gaps and stalls, taken 10x over.
  localparam int RUN_LIMIT_NS = 5_000_000;

  // Tracks the frame state of the checker and queues the verdict each end byte must produce.
  class frame_verdict_board;
    logic [CRC_W-1:0]  seed;
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] win_old;
    logic [BYTE_W-1:0] win_new;
    logic [CNT_W-1:0]  seen;
    res_t              expected_verdicts[$];
    int                failures;

    function new();
      seed = CRC_SEED_RST;
      failures = 0;
      clear_frame();
    endfunction

    // MSB-first CRC-16-CCITT over one byte, no reflection
    static function logic [CRC_W-1:0] crc_after_byte(logic [CRC_W-1:0] c,
                                                     logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
        r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
    endfunction

    function void clear_frame();
      crc = seed;
      win_old = '0;
      win_new = '0;
      seen = '0;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // One accepted input beat.
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      res_t             v;
      logic [CRC_W-1:0] rx;
      if (seen == 0)
        crc = seed;
      if (last) begin
        rx = {win_old, win_new};
        if (seen < CNT_CRC_START) begin
          v.status = ST_SHORT;
          v.computed_crc = '0;
          v.received_crc = '0;
        end else begin
          v.status = (crc == rx) ? ST_OK : ST_MISMATCH;
          v.computed_crc = crc;
          v.received_crc = rx;
        end
        expected_verdicts.push_back(v);
        clear_frame();
      end else begin
        // the oldest windowed byte is payload once it is past the start byte and two non-end bytes follow it
        if (seen >= CNT_CRC_START)
          crc = crc_after_byte(crc, win_old);
        win_old = win_new;
        win_new = b;
        if (seen < CNT_SAT)
          seen++;
      end
    endfunction

    // One accepted result beat against the oldest expectation.
    function void check_verdict(res_t got);
      res_t want;
      if (expected_verdicts.size() == 0) begin
        $error("verdict beat with none expected: status %0d computed 0x%04h received 0x%04h",
               got.status, got.computed_crc, got.received_crc);
        failures++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.computed_crc !== want.computed_crc) begin
        $error("computed_crc: expected 0x%04h, got 0x%04h", want.computed_crc, got.computed_crc);
        failures++;
      end
      if (got.received_crc !== want.received_crc) begin
        $error("received_crc: expected 0x%04h, got 0x%04h", want.received_crc, got.received_crc);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fcc_in_if  in_ch();
  fcc_out_if out_ch();
  fcc_cfg_if cfg_ch();

  framed_crc16_ccitt_checker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_verdict_board board;
  res_t               seen_verdict;

  logic [CRC_W-1:0]  cur_seed;       // seed the frame builder uses for good CRCs
  logic [BYTE_W-1:0] frame_bytes[$]; // frame under construction, start byte first
  int                bytes_sent;
  int                src_burst_left;
  bit                src_gaps_on;
  bit                sink_stalls_on;
  int                sink_run;
  int                sink_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sink side: always ready with stalls off; else runs of ready, then holds of mostly short, sometimes long, stalls.
  always @(posedge clk) begin
    if (!sink_stalls_on) begin
      out_ch.ready <= 1'b1;
    end else if (sink_run != 0) begin
      out_ch.ready <= 1'b1;
      sink_run <= sink_run - 1;
    end else if (sink_hold != 0) begin
      out_ch.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ch.ready <= 1'b0;
      sink_run <= $urandom_range(0, 12);
      sink_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
    end
  end

  // Result monitor: every accepted result beat is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_verdict.status = status_t'(out_ch.status);
      seen_verdict.computed_crc = out_ch.computed_crc;
      seen_verdict.received_crc = out_ch.received_crc;
      board.check_verdict(seen_verdict);
    end
  end

  // Drive one input beat and wait for its handshake. Bursts of random length, random gaps
  // between them; valid is only dropped when a real gap follows, so it never toggles in a step.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    if (src_burst_left == 0) begin
      src_burst_left = $urandom_range(1, 24);
      gap = 0;
      if (src_gaps_on && $urandom_range(0, 3) != 0)
        gap = $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    src_burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Append CRC (high byte first) over everything after the start byte, then an end byte.
  // A corrupted frame gets one flipped bit in payload or CRC, which CRC-16 always catches.
  task automatic close_frame(input bit corrupt);
    logic [CRC_W-1:0] c;
    int               pos;
    c = cur_seed;
    for (int i = 1; i < frame_bytes.size(); i++)
      c = frame_verdict_board::crc_after_byte(c, frame_bytes[i]);
    frame_bytes.push_back(c[15:8]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(BYTE_W'($urandom));
    if (corrupt) begin
      pos = $urandom_range(1, frame_bytes.size() - 2);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  // Mostly well-formed frames with random payload; some corrupted, some junk CRC, some runts.
  task automatic random_frame();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    frame_bytes.delete();
    if (kind < 10) begin
      len = $urandom_range(1, 3);
      repeat (len) frame_bytes.push_back(BYTE_W'($urandom));
    end else begin
      len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 20) : $urandom_range(21, 64);
      frame_bytes.push_back(BYTE_W'($urandom));
      repeat (len) frame_bytes.push_back(BYTE_W'($urandom));
      if (kind < 15)
        repeat (3) frame_bytes.push_back(BYTE_W'($urandom));
      else
        close_frame(kind < 32);
    end
    send_frame();
  endtask

  // Sender holds off until every queued verdict is back, then lets the pipe settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    src_burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called on an idle block, at most once per idle window.
  task automatic write_seed(input logic [CRC_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.crc_seed <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    board.seed = v;
    cur_seed = v;
  endtask

  initial begin
    int               quota;
    logic [CRC_W-1:0] phase_seeds [6];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.crc_seed = '0;
    out_ch.ready = 1'b0;
    sink_run = 0;
    sink_hold = 0;
    src_burst_left = 0;
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    bytes_sent = 0;
    cur_seed = CRC_SEED_RST;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames on the reset seed, no idling.
    // runts: end byte as first, second, third byte
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b1);
    // empty payload: received CRC equals the seed
    send_byte(8'h7E, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b1);
    // empty payload, all-ones CRC: mismatch
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // short payload with a good CRC
    frame_bytes = '{8'h7E, 8'hFF, 8'h00, 8'h80};
    close_frame(1'b0);
    send_frame();
    drain();

    // Random phases, each opening with a seed write; phase 1 runs with no idling on either side.
    phase_seeds = '{16'hFFFF, 16'h1D0F, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
    phase_seeds[2] = CRC_W'($urandom);
    phase_seeds[4] = CRC_W'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_seed(phase_seeds[ph]);
      src_gaps_on = (ph != 1);
      sink_stalls_on = (ph != 1) && (ph != 4);
      quota = bytes_sent + 260;
      while (bytes_sent < quota) begin
        random_frame();
        if ($urandom_range(0, 39) == 0)
          drain();
      end
      drain();
    end

    if (board.failures == 0)
      $display("** framed_crc16_ccitt_checker: PASSED **");
    else
      $display("** framed_crc16_ccitt_checker: FAILED **");
    $finish;
  end

  // Hang guard.
  initial begin
    #RUN_LIMIT_NS;
    $display("** framed_crc16_ccitt_checker: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fcc_pkg.sv
rtl/fcc_ifs.sv
rtl/fcc_in_stage.sv
rtl/fcc_core.sv
rtl/fcc_out_stage.sv
rtl/framed_crc16_ccitt_checker.sv
rtl/fcc_checker.sv
bench/tb_top.sv
